// ===== design/tcsb_pkg.sv =====
package tcsb_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int CALC_W     = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_MODE  = 3'd4;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_DRAW  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] RM_OPAQUE = 2'd0;
  localparam logic [1:0] RM_FILLED = 2'd1;
  localparam logic [1:0] RM_TRANSP = 2'd2;

  localparam logic [2:0] PIV_BOT_LEFT  = 3'd0;
  localparam logic [2:0] PIV_BOT_RIGHT = 3'd1;
  localparam logic [2:0] PIV_TOP_LEFT  = 3'd2;
  localparam logic [2:0] PIV_TOP_RIGHT = 3'd3;
  localparam logic [2:0] PIV_CENTER    = 3'd4;

  localparam logic [7:0] GLYPH_PERCENT = 8'h25;
  localparam logic [7:0] GLYPH_SPACE   = 8'h20;
  localparam logic [3:0] COLOR_WHITE   = 4'd15;
  localparam logic [3:0] COLOR_BLACK   = 4'd0;

  localparam logic [7:0] VIEW_W_RESET = 8'd80;
  localparam logic [6:0] VIEW_H_RESET = 7'd25;

  typedef struct packed {
    logic [3:0] back;
    logic [3:0] fore;
    logic [7:0] glyph;
  } cell_t;

  localparam cell_t BLANK_CELL = '{back: COLOR_BLACK, fore: COLOR_WHITE, glyph: GLYPH_SPACE};

  typedef struct packed {
    logic [7:0] glyph;
    logic [3:0] fore;
    logic [3:0] back;
    logic       written;
  } result_t;

  typedef enum logic [7:0] {
    S_INIT  = 8'b00000001,
    S_IDLE  = 8'b00000010,
    S_CALC  = 8'b00000100,
    S_PLACE = 8'b00001000,
    S_RD    = 8'b00010000,
    S_WR    = 8'b00100000,
    S_CLR   = 8'b01000000,
    S_DONE  = 8'b10000000
  } state_t;

endpackage

// ===== design/tcsb_in_if.sv =====
interface tcsb_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [15:0] sprite_left;
  logic signed [15:0] sprite_bottom;
  logic [7:0]         sprite_cols;
  logic [7:0]         sprite_rows;
  logic               first_cell;
  logic [7:0]         cell_glyph;
  logic [3:0]         cell_fore;
  logic [3:0]         cell_back;
  logic [1:0]         render_mode;
  logic               keep_background;
  logic [12:0]        read_address;

  modport source (
    output valid, opcode, sprite_left, sprite_bottom, sprite_cols, sprite_rows,
           first_cell, cell_glyph, cell_fore, cell_back, render_mode,
           keep_background, read_address,
    input  ready
  );

  modport sink (
    input  valid, opcode, sprite_left, sprite_bottom, sprite_cols, sprite_rows,
           first_cell, cell_glyph, cell_fore, cell_back, render_mode,
           keep_background, read_address,
    output ready
  );
endinterface

// ===== design/tcsb_out_if.sv =====
interface tcsb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_glyph;
  logic [3:0] out_fore;
  logic [3:0] out_back;
  logic       cell_written;

  modport source (
    output valid, out_glyph, out_fore, out_back, cell_written,
    input  ready
  );

  modport sink (
    input  valid, out_glyph, out_fore, out_back, cell_written,
    output ready
  );
endinterface

// ===== design/tcsb_ram.sv =====
module tcsb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ===== design/text_cell_sprite_blitter_core.sv =====
// Character-cell frame buffer with a sprite blitter. Cells live in one single-port-per-side
// memory of MAX_COLS*MAX_ROWS entries (glyph, foreground, background). After reset the block
// runs a clearing pass over all MAX_COLS*MAX_ROWS entries (8192 by default) before it takes the
// first item; configuration writes are taken throughout. A draw or a read steps through the
// states S_CALC (work out the screen position), S_PLACE (form the cell index), S_RD (read the
// cell), S_WR (write back, for a draw only) and S_DONE (hand the result to the output register,
// waiting there until that register is free), then returns to idle. A clear writes one cell per
// cycle, min(W*H, depth) cells in all. One result is returned for every item; the next item is
// taken while the previous result still waits in the output register.
module text_cell_sprite_blitter_core #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  tcsb_in_if.sink                          in_if,
  tcsb_out_if.source                       out_if,
  input  logic                             cfg_we,
  input  logic [tcsb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tcsb_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import tcsb_pkg::*;

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // configuration
  logic [7:0]         view_w_r;
  logic [6:0]         view_h_r;
  logic signed [15:0] cam_x_r;
  logic signed [15:0] cam_y_r;
  logic [2:0]         pivot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_w_r <= VIEW_W_RESET;
      view_h_r <= VIEW_H_RESET;
      cam_x_r  <= '0;
      cam_y_r  <= '0;
      pivot_r  <= PIV_BOT_LEFT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VIEW_WIDTH:  view_w_r <= cfg_wdata[7:0];
        CFG_VIEW_HEIGHT: view_h_r <= cfg_wdata[6:0];
        CFG_CAMERA_X:    cam_x_r  <= signed'(cfg_wdata);
        CFG_CAMERA_Y:    cam_y_r  <= signed'(cfg_wdata);
        CFG_PIVOT_MODE:  pivot_r  <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // control and item registers
  state_t state_r, state_nxt;
  logic [1:0]         op_r;
  logic signed [15:0] left_r;
  logic signed [15:0] bottom_r;
  logic [7:0]         cols_r;
  logic [7:0]         rows_r;
  logic               first_r;
  cell_t              src_r;
  logic [1:0]         mode_r;
  logic               keep_r;
  logic [12:0]        raddr_in_r;

  logic [7:0]       cur_col_r, cur_col_nxt;
  logic [7:0]       cur_row_r, cur_row_nxt;
  logic [AW-1:0]    addr_r, addr_nxt;
  logic             hit_r, hit_nxt;
  logic [CNT_W-1:0] sweep_r;
  logic [CNT_W-1:0] clr_lim_r, clr_lim_nxt;
  result_t          res_r;
  result_t          out_r;
  logic             out_valid_r;

  logic  mem_we;
  logic  [AW-1:0] mem_waddr;
  cell_t mem_wdata;
  cell_t mem_rdata;

  logic in_xfer;
  logic out_free;

  assign in_if.ready = (state_r == S_IDLE);
  assign in_xfer     = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_r || out_if.ready;

  // placement of the current draw cell
  logic signed [CALC_W-1:0] camx, camy, px, py, w_s, h_s;
  logic signed [CALC_W-1:0] px_r, py_r;
  logic [7:0]  col_base, row_base, col_inc;
  logic [7:0]  col_off;
  logic [6:0]  row_off;
  logic [14:0] prod;
  logic [14:0] area;
  logic [16:0] idx17, ra17, lim17;
  logic        vis, draw_en;

  // screen position and counter advance, registered in S_CALC
  always_comb begin
    w_s = signed'(CALC_W'(view_w_r));
    h_s = signed'(CALC_W'(view_h_r));
    unique case (pivot_r)
      PIV_BOT_LEFT: begin
        camx = CALC_W'(cam_x_r);
        camy = CALC_W'(cam_y_r);
      end
      PIV_BOT_RIGHT: begin
        camx = CALC_W'(cam_x_r) - (w_s - CALC_W'(1));
        camy = CALC_W'(cam_y_r);
      end
      PIV_TOP_LEFT: begin
        camx = CALC_W'(cam_x_r);
        camy = CALC_W'(cam_y_r) - (h_s - CALC_W'(1));
      end
      PIV_TOP_RIGHT: begin
        camx = CALC_W'(cam_x_r) - (w_s - CALC_W'(1));
        camy = CALC_W'(cam_y_r) - (h_s - CALC_W'(1));
      end
      PIV_CENTER: begin
        camx = CALC_W'(cam_x_r) - signed'(CALC_W'(view_w_r[7:1]));
        camy = CALC_W'(cam_y_r) - signed'(CALC_W'(view_h_r[6:1]));
      end
      default: begin
        camx = CALC_W'(1);
        camy = CALC_W'(1);
      end
    endcase

    col_base = first_r ? 8'd0 : cur_col_r;
    row_base = first_r ? 8'd0 : cur_row_r;

    px = CALC_W'(left_r) - camx + CALC_W'(1) + signed'(CALC_W'(col_base));
    py = CALC_W'(bottom_r) - camy + signed'(CALC_W'(rows_r)) - signed'(CALC_W'(row_base));

    area  = 15'(view_w_r) * 15'(view_h_r);
    lim17 = (17'(area) > 17'(DEPTH)) ? 17'(DEPTH) : 17'(area);
    clr_lim_nxt = CNT_W'(lim17);

    col_inc = col_base + 8'd1;
    if (col_inc >= cols_r) begin
      cur_col_nxt = 8'd0;
      cur_row_nxt = row_base + 8'd1;
    end else begin
      cur_col_nxt = col_inc;
      cur_row_nxt = row_base;
    end
  end

  // clipping, color key and cell index, registered in S_PLACE
  always_comb begin
    vis = (px_r >= CALC_W'(1)) && (px_r <= w_s) && (py_r >= CALC_W'(1)) && (py_r <= h_s);

    col_off = 8'(px_r - CALC_W'(1));
    row_off = 7'(h_s - py_r);
    prod    = 15'(view_w_r) * 15'(row_off);
    idx17   = 17'(col_off) + 17'(prod);
    ra17    = 17'(raddr_in_r);

    case (mode_r)
      RM_OPAQUE: draw_en = 1'b1;
      RM_FILLED: draw_en = (src_r.glyph != GLYPH_PERCENT);
      RM_TRANSP: draw_en = (src_r.glyph != GLYPH_SPACE);
      default:   draw_en = 1'b0;
    endcase

    if (op_r == OP_DRAW) begin
      addr_nxt = idx17[AW-1:0];
      hit_nxt  = draw_en && vis && (idx17 < 17'(DEPTH));
    end else begin
      addr_nxt = ra17[AW-1:0];
      hit_nxt  = (ra17 < 17'(DEPTH));
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: if (sweep_r == CNT_W'(DEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE: if (in_xfer) state_nxt = S_CALC;
      S_CALC: begin
        case (op_r) inside
          OP_CLEAR:         state_nxt = S_CLR;
          OP_DRAW, OP_READ: state_nxt = S_PLACE;
          default:          state_nxt = S_DONE;
        endcase
      end
      S_PLACE: state_nxt = S_RD;
      S_RD:    state_nxt = S_WR;
      S_WR:    state_nxt = S_DONE;
      S_CLR:   if (sweep_r == clr_lim_r) state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      sweep_r     <= '0;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_INIT || (state_r == S_CLR && sweep_r != clr_lim_r)) begin
        sweep_r <= sweep_r + CNT_W'(1);
      end else if (state_r == S_CALC) begin
        sweep_r <= '0;
      end
      if (state_r == S_CALC && op_r == OP_DRAW) begin
        cur_col_r <= cur_col_nxt;
        cur_row_r <= cur_row_nxt;
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r       <= in_if.opcode;
      left_r     <= in_if.sprite_left;
      bottom_r   <= in_if.sprite_bottom;
      cols_r     <= in_if.sprite_cols;
      rows_r     <= in_if.sprite_rows;
      first_r    <= in_if.first_cell;
      src_r      <= '{back: in_if.cell_back, fore: in_if.cell_fore, glyph: in_if.cell_glyph};
      mode_r     <= in_if.render_mode;
      keep_r     <= in_if.keep_background;
      raddr_in_r <= in_if.read_address;
    end
    if (state_r == S_CALC) begin
      px_r      <= px;
      py_r      <= py;
      clr_lim_r <= clr_lim_nxt;
      res_r     <= '0;
    end
    if (state_r == S_PLACE) begin
      addr_r <= addr_nxt;
      hit_r  <= hit_nxt;
    end
    if (state_r == S_WR) begin
      if (op_r == OP_READ && hit_r) begin
        res_r.glyph <= mem_rdata.glyph;
        res_r.fore  <= mem_rdata.fore;
        res_r.back  <= mem_rdata.back;
      end
      if (op_r == OP_DRAW) begin
        res_r.written <= hit_r;
      end
    end
    if (state_r == S_DONE && out_free) begin
      out_r <= res_r;
    end
  end

  // memory write port: clearing sweeps, or the draw write-back
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep_r[AW-1:0];
    mem_wdata = BLANK_CELL;
    if (state_r == S_INIT || (state_r == S_CLR && sweep_r != clr_lim_r)) begin
      mem_we = 1'b1;
    end else if (state_r == S_WR && op_r == OP_DRAW && hit_r) begin
      mem_we    = 1'b1;
      mem_waddr = addr_r;
      mem_wdata = '{back: keep_r ? mem_rdata.back : src_r.back,
                    fore: src_r.fore, glyph: src_r.glyph};
    end
  end

  tcsb_ram #(
    .WIDTH ($bits(cell_t)),
    .DEPTH (DEPTH)
  ) u_cells (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (addr_r),
    .rdata (mem_rdata)
  );

  assign out_if.valid        = out_valid_r;
  assign out_if.out_glyph    = out_r.glyph;
  assign out_if.out_fore     = out_r.fore;
  assign out_if.out_back     = out_r.back;
  assign out_if.cell_written = out_r.written;

  a_we_states: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_INIT || state_r == S_CLR || state_r == S_WR))
    else $error("cell memory written outside a sweep or write-back");

  a_written_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.cell_written) |->
      (out_if.out_glyph == 8'd0 && out_if.out_fore == 4'd0 && out_if.out_back == 4'd0))
    else $error("draw result carries cell data");

  a_wr_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR) |=> (state_r == S_DONE))
    else $error("write-back not followed by result");

  a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> (sweep_r <= clr_lim_r))
    else $error("clear sweep ran past its limit");

endmodule

// ===== verif/testbench.sv =====
module testbench;
  import tcsb_pkg::*;

  localparam int MAX_COLS     = 128;
  localparam int MAX_ROWS     = 64;
  localparam int STORE_DEPTH  = MAX_COLS * MAX_ROWS;
  localparam int STALL_LIMIT  = 40000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 300;
  localparam int RECENT_MAX   = 16;

  // codes the package leaves unnamed
  localparam logic [1:0] OP_NOP      = 2'd3;
  localparam logic [1:0] RM_NONE     = 2'd3;
  localparam logic [2:0] PIV_FIXED_A = 3'd5;
  localparam logic [2:0] PIV_FIXED_B = 3'd6;
  localparam logic [2:0] PIV_FIXED_C = 3'd7;

  typedef struct {
    bit [1:0]         opcode;
    bit signed [15:0] sprite_left;
    bit signed [15:0] sprite_bottom;
    bit [7:0]         sprite_cols;
    bit [7:0]         sprite_rows;
    bit               first_cell;
    bit [7:0]         cell_glyph;
    bit [3:0]         cell_fore;
    bit [3:0]         cell_back;
    bit [1:0]         render_mode;
    bit               keep_background;
    bit [12:0]        read_address;
  } blit_item_t;

  typedef struct {
    int w;
    int h;
    int cam_x;
    int cam_y;
    int pivot;
    int count;
  } view_setup_t;

  class blit_scoreboard;
    cell_t            store [STORE_DEPTH];
    bit [7:0]         col_pos;
    bit [7:0]         row_pos;
    bit [7:0]         view_w;
    bit [6:0]         view_h;
    bit signed [15:0] cam_x;
    bit signed [15:0] cam_y;
    bit [2:0]         pivot;
    result_t          pending_results[$];
    int               recent_writes[$];
    int               errors;

    function new();
      foreach (store[i]) store[i] = BLANK_CELL;
      col_pos = '0;
      row_pos = '0;
      view_w  = VIEW_W_RESET;
      view_h  = VIEW_H_RESET;
      cam_x   = '0;
      cam_y   = '0;
      pivot   = PIV_BOT_LEFT;
      errors  = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_VIEW_WIDTH:  view_w = data[7:0];
        CFG_VIEW_HEIGHT: view_h = data[6:0];
        CFG_CAMERA_X:    cam_x  = data;
        CFG_CAMERA_Y:    cam_y  = data;
        CFG_PIVOT_MODE:  pivot  = data[2:0];
        default: ;
      endcase
    endfunction

    // world position of the view's bottom-left cell
    function void cam_corner(output int cx, output int cy);
      int w;
      int h;
      w = view_w;
      h = view_h;
      case (pivot)
        PIV_BOT_LEFT:  begin cx = cam_x;         cy = cam_y;         end
        PIV_BOT_RIGHT: begin cx = cam_x - (w-1); cy = cam_y;         end
        PIV_TOP_LEFT:  begin cx = cam_x;         cy = cam_y - (h-1); end
        PIV_TOP_RIGHT: begin cx = cam_x - (w-1); cy = cam_y - (h-1); end
        PIV_CENTER:    begin cx = cam_x - w/2;   cy = cam_y - h/2;   end
        default:       begin cx = 1;             cy = 1;             end
      endcase
    endfunction

    function void apply_op(blit_item_t it);
      result_t r;
      cell_t   c;
      int      cx, cy, px, py, w, h, n, idx;
      bit      visible_key;
      r = '0;
      w = view_w;
      h = view_h;
      case (it.opcode)
        OP_CLEAR: begin
          n = w * h;
          if (n > STORE_DEPTH) n = STORE_DEPTH;
          for (int i = 0; i < n; i++) store[i] = BLANK_CELL;
        end
        OP_DRAW: begin
          if (it.first_cell) begin
            col_pos = '0;
            row_pos = '0;
          end
          cam_corner(cx, cy);
          px = int'(it.sprite_left) - cx + 1 + int'(col_pos);
          py = int'(it.sprite_bottom) - cy + int'(it.sprite_rows) - int'(row_pos);
          case (it.render_mode)
            RM_OPAQUE: visible_key = 1'b1;
            RM_FILLED: visible_key = (it.cell_glyph != GLYPH_PERCENT);
            RM_TRANSP: visible_key = (it.cell_glyph != GLYPH_SPACE);
            default:   visible_key = 1'b0;
          endcase
          if (visible_key && px >= 1 && px <= w && py >= 1 && py <= h) begin
            idx = (px - 1) + w * (h - py);
            if (idx < STORE_DEPTH) begin
              c = store[idx];
              c.glyph = it.cell_glyph;
              c.fore  = it.cell_fore;
              if (!it.keep_background) c.back = it.cell_back;
              store[idx] = c;
              r.written = 1'b1;
              recent_writes = {recent_writes, idx};
              if (recent_writes.size() > RECENT_MAX) void'(recent_writes.pop_front());
            end
          end
          col_pos = col_pos + 8'd1;
          if (col_pos >= it.sprite_cols) begin
            col_pos = '0;
            row_pos = row_pos + 8'd1;
          end
        end
        OP_READ: begin
          if (it.read_address < STORE_DEPTH) begin
            c = store[it.read_address];
            r.glyph = c.glyph;
            r.fore  = c.fore;
            r.back  = c.back;
          end
        end
        default: ;
      endcase
      pending_results = {pending_results, r};
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      errors++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, glyph", got.glyph, 0);
        return;
      end
      want = pending_results.pop_front();
      if (got.glyph !== want.glyph) report_mismatch("glyph", got.glyph, want.glyph);
      if (got.fore !== want.fore) report_mismatch("fore", got.fore, want.fore);
      if (got.back !== want.back) report_mismatch("back", got.back, want.back);
      if (got.written !== want.written) report_mismatch("written", got.written, want.written);
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tcsb_in_if  in_if ();
  tcsb_out_if out_if ();

  text_cell_sprite_blitter_core #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .out_if   (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  blit_scoreboard sb = new();

  int send_idle_pct;
  int recv_idle_pct;
  int items_sent;
  int stall_cycles;
  bit long_hold_req;

  view_setup_t setups [9] = '{
    '{80,  25,  0,      0,      PIV_BOT_LEFT,  200},
    '{128, 64,  -32768, 32767,  PIV_BOT_RIGHT, 200},
    '{1,   1,   32767,  -32768, PIV_TOP_LEFT,  180},
    '{37,  13,  -5,     7,      PIV_CENTER,    200},
    '{20,  9,   100,    -100,   PIV_TOP_RIGHT, 200},
    '{255, 127, 3,      3,      PIV_FIXED_C,   180},
    '{0,   10,  0,      0,      PIV_FIXED_A,   120},
    '{16,  0,   -1,     -1,     PIV_FIXED_B,   120},
    '{64,  32,  1000,   1000,   PIV_CENTER,    200}
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic blit_item_t random_fields();
    blit_item_t it;
    it.opcode          = 2'($urandom_range(3));
    it.sprite_left     = 16'($urandom);
    it.sprite_bottom   = 16'($urandom);
    it.sprite_cols     = 8'($urandom);
    it.sprite_rows     = 8'($urandom);
    it.first_cell      = 1'($urandom);
    it.cell_glyph      = 8'($urandom);
    it.cell_fore       = 4'($urandom);
    it.cell_back       = 4'($urandom);
    it.render_mode     = 2'($urandom_range(3));
    it.keep_background = 1'($urandom);
    it.read_address    = 13'($urandom);
    return it;
  endfunction

  function automatic bit [7:0] pick_glyph();
    int r;
    r = $urandom_range(99);
    if (r < 20) return GLYPH_PERCENT;
    if (r < 40) return GLYPH_SPACE;
    return 8'($urandom_range(255));
  endfunction

  function automatic blit_item_t draw_cell(int left, int bottom, int cols, int rows, bit first,
                                           bit [7:0] glyph, bit [1:0] mode, bit keep);
    blit_item_t it;
    it                 = random_fields();
    it.opcode          = OP_DRAW;
    it.sprite_left     = 16'(left);
    it.sprite_bottom   = 16'(bottom);
    it.sprite_cols     = 8'(cols);
    it.sprite_rows     = 8'(rows);
    it.first_cell      = first;
    it.cell_glyph      = glyph;
    it.cell_fore       = glyph[7:4];
    it.cell_back       = glyph[3:0];
    it.render_mode     = mode;
    it.keep_background = keep;
    return it;
  endfunction

  function automatic blit_item_t read_cell(int addr);
    blit_item_t it;
    it              = random_fields();
    it.opcode       = OP_READ;
    it.read_address = 13'(addr);
    return it;
  endfunction

  task automatic put_fields(blit_item_t it);
    in_if.opcode          <= it.opcode;
    in_if.sprite_left     <= it.sprite_left;
    in_if.sprite_bottom   <= it.sprite_bottom;
    in_if.sprite_cols     <= it.sprite_cols;
    in_if.sprite_rows     <= it.sprite_rows;
    in_if.first_cell      <= it.first_cell;
    in_if.cell_glyph      <= it.cell_glyph;
    in_if.cell_fore       <= it.cell_fore;
    in_if.cell_back       <= it.cell_back;
    in_if.render_mode     <= it.render_mode;
    in_if.keep_background <= it.keep_background;
    in_if.read_address    <= it.read_address;
  endtask

  // valid stays high between back-to-back items, it only drops for a gap
  task automatic drive_item(blit_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    put_fields(it);
    do @(posedge clk); while (!in_if.ready);
    items_sent++;
  endtask

  task automatic send_read();
    blit_item_t it;
    int r, lim;
    it        = random_fields();
    it.opcode = OP_READ;
    r         = $urandom_range(99);
    lim       = sb.view_w * sb.view_h;
    if (lim > STORE_DEPTH) lim = STORE_DEPTH;
    if (lim < 1) lim = 1;
    if (r < 55 && sb.recent_writes.size() > 0)
      it.read_address = 13'(sb.recent_writes[$urandom_range(sb.recent_writes.size() - 1)]);
    else if (r < 80)
      it.read_address = 13'($urandom_range(lim - 1));
    drive_item(it);
  endtask

  task automatic send_sprite();
    blit_item_t it;
    int cx, cy, w, h, cols, rows, cells, r;
    it        = random_fields();
    it.opcode = OP_DRAW;
    r         = $urandom_range(99);
    if (r < 88)      cols = $urandom_range(1, 6);
    else if (r < 95) cols = $urandom_range(7, 255);
    else             cols = 0;
    rows  = ($urandom_range(9) == 0) ? $urandom_range(7, 255) : $urandom_range(1, 6);
    cells = (cols == 0 ? 1 : cols) * rows;
    // a few cells past the last sprite row
    if ($urandom_range(3) == 0) cells += $urandom_range(1, 3);
    if (cells > 40) cells = $urandom_range(8, 40);
    sb.cam_corner(cx, cy);
    w = sb.view_w;
    h = sb.view_h;
    it.sprite_left   = 16'(cx - cols - 1 + $urandom_range(w + cols + 2));
    it.sprite_bottom = 16'(cy - rows - 1 + $urandom_range(h + rows + 2));
    it.sprite_cols   = 8'(cols);
    it.sprite_rows   = 8'(rows);
    r = $urandom_range(99);
    it.render_mode = r < 40 ? RM_OPAQUE : r < 65 ? RM_FILLED : r < 93 ? RM_TRANSP : RM_NONE;
    for (int k = 0; k < cells; k++) begin
      it.first_cell      = (k == 0) || ($urandom_range(59) == 0);
      it.cell_glyph      = pick_glyph();
      it.cell_fore       = 4'($urandom);
      it.cell_back       = 4'($urandom);
      it.keep_background = 1'($urandom);
      // reads in the middle of a sprite must leave the counters alone
      if (k > 0 && $urandom_range(29) == 0) send_read();
      drive_item(it);
    end
  endtask

  task automatic run_random(int n);
    blit_item_t it;
    int target, r;
    target = items_sent + n;
    while (items_sent < target) begin
      r = $urandom_range(99);
      if (r < 55) begin
        send_sprite();
      end else if (r < 82) begin
        send_read();
      end else if (r < 85) begin
        it        = random_fields();
        it.opcode = OP_CLEAR;
        drive_item(it);
      end else if (r < 88) begin
        it        = random_fields();
        it.opcode = OP_NOP;
        drive_item(it);
      end else begin
        it = random_fields();
        if (it.opcode == OP_NOP) it.opcode = OP_DRAW;
        drive_item(it);
      end
    end
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_view(view_setup_t s);
    logic [CFG_IDX_W-1:0]  regs [5];
    logic [CFG_DATA_W-1:0] vals [5];
    regs = '{CFG_VIEW_WIDTH, CFG_VIEW_HEIGHT, CFG_CAMERA_X, CFG_CAMERA_Y, CFG_PIVOT_MODE};
    vals = '{16'(s.w), 16'(s.h), 16'(s.cam_x), 16'(s.cam_y), 16'(s.pivot)};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.set_reg(regs[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin : input_monitor
    blit_item_t seen;
    if (rst_n && in_if.valid && in_if.ready) begin
      seen.opcode          = in_if.opcode;
      seen.sprite_left     = in_if.sprite_left;
      seen.sprite_bottom   = in_if.sprite_bottom;
      seen.sprite_cols     = in_if.sprite_cols;
      seen.sprite_rows     = in_if.sprite_rows;
      seen.first_cell      = in_if.first_cell;
      seen.cell_glyph      = in_if.cell_glyph;
      seen.cell_fore       = in_if.cell_fore;
      seen.cell_back       = in_if.cell_back;
      seen.render_mode     = in_if.render_mode;
      seen.keep_background = in_if.keep_background;
      seen.read_address    = in_if.read_address;
      sb.apply_op(seen);
    end
  end

  always @(posedge clk) begin : result_monitor
    result_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.glyph   = out_if.out_glyph;
      got.fore    = out_if.out_fore;
      got.back    = out_if.out_back;
      got.written = out_if.cell_written;
      sb.check_result(got);
    end
  end

  // counts cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    stall_cycles  = 0;
    items_sent    = 0;
    long_hold_req = 1'b0;
    send_idle_pct = 18;
    recv_idle_pct = 50;
    rst_n       <= 1'b0;
    in_if.valid <= 1'b0;
    put_fields(random_fields());
    cfg_we      <= 1'b0;
    cfg_index   <= CFG_VIEW_WIDTH;
    cfg_wdata   <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset view: 80x25, camera corner at the origin
    drive_item(read_cell(0));
    drive_item(read_cell(STORE_DEPTH - 1));
    drive_item(draw_cell(0, 0, 3, 2, 1'b1, 8'h41, RM_OPAQUE, 1'b0));
    drive_item(draw_cell(0, 0, 3, 2, 1'b0, GLYPH_PERCENT, RM_FILLED, 1'b0));
    drive_item(draw_cell(0, 0, 3, 2, 1'b0, 8'h42, RM_FILLED, 1'b0));
    drive_item(draw_cell(0, 0, 3, 2, 1'b0, GLYPH_SPACE, RM_TRANSP, 1'b0));
    drive_item(draw_cell(0, 0, 3, 2, 1'b0, 8'hFF, RM_TRANSP, 1'b1));
    drive_item(draw_cell(0, 0, 3, 2, 1'b0, 8'h00, RM_NONE, 1'b0));
    // row below the sprite, clipped at the view bottom
    drive_item(draw_cell(0, 0, 3, 2, 1'b0, 8'h43, RM_OPAQUE, 1'b0));
    // redraw over the first cell keeping its background
    drive_item(draw_cell(0, 1, 1, 1, 1'b1, 8'h5A, RM_OPAQUE, 1'b1));
    drive_item(read_cell(1840));
    drive_item(read_cell(1841));
    drive_item(read_cell(1842));
    drive_item(read_cell(1920));
    drive_item(read_cell(1921));
    drive_item(draw_cell(-32768, -32768, 255, 255, 1'b1, GLYPH_PERCENT, RM_OPAQUE, 1'b1));
    drive_item(draw_cell(32767, 32767, 0, 255, 1'b1, GLYPH_SPACE, RM_TRANSP, 1'b0));
    drive_item(draw_cell(32767, 32767, 0, 255, 1'b0, 8'hFF, RM_FILLED, 1'b1));
    drive_item(draw_cell(79, 24, 1, 1, 1'b1, 8'h7E, RM_OPAQUE, 1'b0));
    drive_item(read_cell(79));
    begin : nop_all_ones
      blit_item_t it;
      it                 = draw_cell(-1, -1, 255, 255, 1'b1, 8'hFF, RM_NONE, 1'b1);
      it.opcode          = OP_NOP;
      it.read_address    = '1;
      drive_item(it);
      it.opcode          = OP_CLEAR;
      drive_item(it);
    end
    drive_item(read_cell(1840));

    for (int p = 0; p < 9; p++) begin
      wait_drained();
      send_idle_pct = p < 3 ? 18 : p < 6 ? 50 : 0;
      recv_idle_pct = p < 3 ? 50 : p < 6 ? 18 : 0;
      load_view(setups[p]);
      if (p == 8) begin
        run_random(60);
        // receiver stalls long enough for the input side to back up
        long_hold_req = 1'b1;
        run_random(setups[p].count - 60);
      end else begin
        run_random(setups[p].count);
      end
    end
    wait_drained();

    if (sb.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
design/tcsb_pkg.sv
design/tcsb_in_if.sv
design/tcsb_out_if.sv
design/tcsb_ram.sv
design/text_cell_sprite_blitter_core.sv
verif/testbench.sv
